[design/stick_shaping_slew_limiter_defines.svh]
// ----------------------------------------------------------------------------
// Stick shaping slew limiter assertion macros
// Shared property macros for the checker of the stick shaping block.
// ----------------------------------------------------------------------------
`ifndef STICK_SHAPING_SLEW_LIMITER_DEFINES_SVH
`define STICK_SHAPING_SLEW_LIMITER_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define SSL_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stick shaping property failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define SSL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stick shaping property failed");

`endif

[design/ssl_pkg.sv]
// ----------------------------------------------------------------------------
// Stick shaping slew limiter package
// Shared constants and the command type between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ssl_pkg;

   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int CSR_ADDR_WIDTH       = 1;

   localparam logic [CSR_ADDR_WIDTH-1:0] REG_DEADBAND = 1'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_SLEW     = 1'd1;

   typedef enum logic [1:0] {
      MUL_SQ_LEFT,
      MUL_CUBE_LEFT,
      MUL_SQ_RIGHT,
      MUL_CUBE_RIGHT
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      mul_op_type mul_op;
      logic       store_left;
      logic       store_right;
   } dp_cmd_type;

endpackage

`default_nettype wire

[design/ssl_ctrl.sv]
// ----------------------------------------------------------------------------
// Stick shaping controller
// Sequences the shared multiplier and the shaper over one item.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   output ssl_pkg::dp_cmd_type cmd
);
   import ssl_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_LEFT,
      ST_CUBE_LEFT,
      ST_SQ_RIGHT,
      ST_CUBE_RIGHT,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // The output register may be reloaded when empty or drained this cycle.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd = '{load: 1'b0, mul_en: 1'b0, mul_op: MUL_SQ_LEFT,
              store_left: 1'b0, store_right: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_tvalid;
         end
         ST_SQ_LEFT: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_SQ_LEFT;
         end
         ST_CUBE_LEFT: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_CUBE_LEFT;
         end
         ST_SQ_RIGHT: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_op     = MUL_SQ_RIGHT;
            cmd.store_left = 1'b1;
         end
         ST_CUBE_RIGHT: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_CUBE_RIGHT;
         end
         ST_FINISH: begin
            cmd.store_right = out_free;
         end
         default: begin
            cmd.load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_SQ_LEFT;
               end
            end
            ST_SQ_LEFT:    state_ff <= ST_CUBE_LEFT;
            ST_CUBE_LEFT:  state_ff <= ST_SQ_RIGHT;
            ST_SQ_RIGHT:   state_ff <= ST_CUBE_RIGHT;
            ST_CUBE_RIGHT: state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

[design/ssl_datapath.sv]
// ----------------------------------------------------------------------------
// Stick shaping datapath
// Configuration registers, one shared multiplier, the deadband and slew
// shaper, the previous outputs and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_datapath #(
   parameter int SAMPLE_WIDTH = ssl_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  ssl_pkg::dp_cmd_type                  cmd,
   input  wire                                  csr_we,
   input  wire  [ssl_pkg::CSR_ADDR_WIDTH-1:0]   csr_addr,
   input  wire  [SAMPLE_WIDTH-2:0]              csr_wdata,
   input  wire  signed [SAMPLE_WIDTH-1:0]       left_stick,
   input  wire  signed [SAMPLE_WIDTH-1:0]       right_stick,
   output logic signed [SAMPLE_WIDTH-1:0]       left_drive,
   output logic signed [SAMPLE_WIDTH-1:0]       right_drive
);
   import ssl_pkg::*;

   localparam int W         = SAMPLE_WIDTH;
   localparam int FRAC_BITS = SAMPLE_WIDTH - 1;
   localparam longint unsigned DB_RESET   = ((64'd1 << FRAC_BITS) + 64'd10) / 64'd20;
   localparam longint unsigned SLEW_RESET = ((64'd3 << FRAC_BITS) + 64'd5) / 64'd10;

   logic        [FRAC_BITS-1:0] db_ff;
   logic        [FRAC_BITS-1:0] slew_ff;
   logic signed [W-1:0]         x_left_ff;
   logic signed [W-1:0]         x_right_ff;
   logic signed [2*W:0]         mul_ff;
   logic signed [W-1:0]         prev_left_ff;
   logic signed [W-1:0]         prev_right_ff;
   logic signed [W-1:0]         out_left_ff;
   logic signed [W-1:0]         out_right_ff;

   logic signed [W:0]   mul_a;
   logic signed [W-1:0] mul_b;
   logic signed [W:0]   square;
   logic signed [W-1:0] cube;
   logic signed [W-1:0] prev_sel;
   logic signed [W+1:0] cube_x;
   logic signed [W+1:0] mag;
   logic signed [W+1:0] db_x;
   logic signed [W+1:0] slew_x;
   logic signed [W+1:0] prev_x;
   logic signed [W+1:0] gated;
   logic signed [W+1:0] upper;
   logic signed [W+1:0] lower;
   logic signed [W+1:0] shaped_x;
   logic signed [W-1:0] shaped;

   // A square is never negative and at most one, so its integer part
   // fits in the upper half of the product with a zero sign bit added.
   assign square = $signed({1'b0, mul_ff[2*FRAC_BITS:FRAC_BITS]});
   // The cube always fits the sample range, so truncating the shifted
   // product is the floor shift.
   assign cube   = $signed(mul_ff[FRAC_BITS +: W]);

   always_comb begin
      case (cmd.mul_op)
         MUL_SQ_LEFT: begin
            mul_a = (W+1)'(x_left_ff);
            mul_b = x_left_ff;
         end
         MUL_CUBE_LEFT: begin
            mul_a = square;
            mul_b = x_left_ff;
         end
         MUL_SQ_RIGHT: begin
            mul_a = (W+1)'(x_right_ff);
            mul_b = x_right_ff;
         end
         MUL_CUBE_RIGHT: begin
            mul_a = square;
            mul_b = x_right_ff;
         end
         default: begin
            mul_a = square;
            mul_b = x_left_ff;
         end
      endcase
   end

   // Deadband and slew clamp, shared by the two channels.
   always_comb begin
      prev_sel = cmd.store_left ? prev_left_ff : prev_right_ff;
      cube_x   = (W+2)'(cube);
      mag      = (cube_x < 0) ? -cube_x : cube_x;
      db_x     = $signed({3'b000, db_ff});
      slew_x   = $signed({3'b000, slew_ff});
      prev_x   = (W+2)'(prev_sel);
      gated    = (mag < db_x) ? '0 : cube_x;
      upper    = prev_x + slew_x;
      lower    = prev_x - slew_x;
      if (gated > upper) begin
         shaped_x = upper;
      end else if (gated < lower) begin
         shaped_x = lower;
      end else begin
         shaped_x = gated;
      end
      shaped = $signed(shaped_x[W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         db_ff         <= FRAC_BITS'(DB_RESET);
         slew_ff       <= FRAC_BITS'(SLEW_RESET);
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               REG_DEADBAND: db_ff   <= csr_wdata;
               REG_SLEW:     slew_ff <= csr_wdata;
               default:      db_ff   <= db_ff;
            endcase
         end
         if (cmd.store_left) begin
            prev_left_ff <= shaped;
         end
         if (cmd.store_right) begin
            prev_right_ff <= shaped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_left_ff  <= left_stick;
         x_right_ff <= right_stick;
      end
      if (cmd.mul_en) begin
         mul_ff <= mul_a * mul_b;
      end
      if (cmd.store_right) begin
         out_left_ff  <= prev_left_ff;
         out_right_ff <= shaped;
      end
   end

   assign left_drive  = out_left_ff;
   assign right_drive = out_right_ff;

endmodule

`default_nettype wire

[design/stick_shaping_slew_limiter.sv]
// An accepted item takes four passes through the single shared multiplier
// (square and cube per channel) between the accept and finish steps. Its
// result is registered at finish; req_tready stays low until the return to idle.
// A result waiting on rsp_tready holds the finish step until it is taken.
// Reset (synchronous, active high) clears the previous outputs to zero and
// loads deadband_threshold = 0.05 and slew_step = 0.3 in Q1.F.
// ----------------------------------------------------------------------------
// Stick shaping slew limiter
// Two-channel tank-drive shaper: cube, deadband and slew-rate clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module stick_shaping_slew_limiter #(
   parameter int SAMPLE_WIDTH = ssl_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // req_tdata: left_stick, right_stick (from bit 0 up), zero padded
   input  wire  [((2*SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // rsp_tdata: left_drive, right_drive (from bit 0 up), zero padded
   output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input  wire                                csr_we,
   input  wire  [ssl_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  wire  [SAMPLE_WIDTH-2:0]            csr_wdata
);
   import ssl_pkg::*;

   localparam int TDATA_WIDTH = ((2*SAMPLE_WIDTH+7)/8)*8;

   dp_cmd_type                cmd;
   logic signed [SAMPLE_WIDTH-1:0] left_stick;
   logic signed [SAMPLE_WIDTH-1:0] right_stick;
   logic signed [SAMPLE_WIDTH-1:0] left_drive;
   logic signed [SAMPLE_WIDTH-1:0] right_drive;

   assign left_stick  = $signed(req_tdata[SAMPLE_WIDTH-1:0]);
   assign right_stick = $signed(req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
   assign rsp_tdata   = TDATA_WIDTH'({right_drive, left_drive});

   ssl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ssl_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .left_stick  (left_stick),
      .right_stick (right_stick),
      .left_drive  (left_drive),
      .right_drive (right_drive)
   );

endmodule

`default_nettype wire

[design/ssl_checker.sv]
// ----------------------------------------------------------------------------
// Stick shaping port checker
// Watches the top-level ports for sequencing and output stability.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stick_shaping_slew_limiter_defines.svh"

module ssl_checker #(
   parameter int TDATA_WIDTH = 32
) (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_tvalid,
   input wire                   req_tready,
   input wire                   rsp_tvalid,
   input wire                   rsp_tready,
   input wire [TDATA_WIDTH-1:0] rsp_tdata
);

   // A stalled result keeps its value.
   `SSL_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // The block works on one item at a time: busy right after an accept.
   `SSL_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)

   // A fresh result only appears out of a busy cycle.
   `SSL_ASSERT_SAME(a_rsp_from_busy, $rose(rsp_tvalid), $past(!req_tready))

endmodule

bind stick_shaping_slew_limiter ssl_checker #(
   .TDATA_WIDTH (TDATA_WIDTH)
) u_ssl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
